// ----- rtl/hvn2d_pkg.sv -----
// Shared constants and types for the hashed 2D value noise block.
package hvn2d_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W       = 32;
   localparam int VALUE_W       = 24;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [31:0] PRIME_X    = 32'd73856093;
   localparam logic [31:0] PRIME_Y    = 32'd19349663;
   localparam logic [31:0] PRIME_SEED = 32'd83492791;
   localparam logic [31:0] MIX_MUL_A  = 32'h7feb352d;
   localparam logic [31:0] MIX_MUL_B  = 32'h846ca68b;

   typedef logic [CSR_ADDR_W-3:0] reg_index_type;
   localparam reg_index_type REG_NOISE_SEED = reg_index_type'(0);

   typedef logic [VALUE_W-1:0] value_type;

endpackage

// ----- rtl/hvn2d_chan_if.sv -----
// Request and response channel interfaces for the noise block.
interface hvn2d_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [hvn2d_pkg::COORD_W-1:0] x_pos;
   logic signed [hvn2d_pkg::COORD_W-1:0] y_pos;

   modport source (output valid, output x_pos, output y_pos, input ready);
   modport sink (input valid, input x_pos, input y_pos, output ready);
endinterface

interface hvn2d_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [hvn2d_pkg::VALUE_W-1:0]     noise_value;

   modport source (output valid, output noise_value, input ready);
   modport sink (input valid, input noise_value, output ready);
endinterface

// ----- rtl/hashed_value_noise_2d_top.sv -----
// Top level of the hashed 2D value noise pipeline.
//
//   channel  | dir | payload                     | handshake
//   req      | in  | x_pos, y_pos (Q.FRAC_BITS)  | valid/ready
//   rsp      | out | noise_value (24 bit)        | valid/ready
//   csr      | in  | noise_seed at byte addr 0   | APB write/read
//
// Nine register stages: one request per cycle while a stalled response does not back up to the input.
// The stage count is set by the multiplier chain: lattice, two mixer rounds, two lerps.
// Reset clears all stage valid bits and the seed.
// A stalled response holds the last stage and every full stage behind it; empty stages upstream keep filling.
module hashed_value_noise_2d_top #(
   parameter int FRAC_BITS = hvn2d_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   hvn2d_req_if.sink                           req,
   hvn2d_rsp_if.source                         rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hvn2d_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [hvn2d_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [hvn2d_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import hvn2d_pkg::*;

   localparam int FW   = FRAC_BITS;
   localparam int NSTG = 9;
   localparam int DW   = VALUE_W + 1;
   localparam int PW   = DW + FW + 1;

   // ---------------- configuration ----------------
   logic        csr_sel;
   logic        csr_wr;
   logic [31:0] seed_ff, seed_in;
   logic [31:0] seed_mix_ff, seed_mix_in;

   assign csr_pready = 1'b1;
   assign csr_sel    = (csr_paddr[CSR_ADDR_W-1:2] == REG_NOISE_SEED);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_sel ? seed_ff : '0;
   assign seed_in     = csr_pwdata;
   assign seed_mix_in = csr_pwdata * PRIME_SEED;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= '0;
         seed_mix_ff <= '0;
      end else if (csr_wr && csr_sel) begin
         seed_ff     <= seed_in;
         seed_mix_ff <= seed_mix_in;
      end
   end

   // ---------------- flow control ----------------
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req.valid;
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // ---------------- stage 1: floor, lattice products, t*t ----------------
   logic [31:0]     xi, yi;
   logic [31:0]     s1_hx_ff, s1_hx_in, s1_hy_ff, s1_hy_in;
   logic [FW-1:0]   s1_tx_ff, s1_tx_in, s1_ty_ff, s1_ty_in;
   logic [2*FW-1:0] s1_tx2_ff, s1_tx2_in, s1_ty2_ff, s1_ty2_in;

   assign xi        = 32'(req.x_pos >>> FW);
   assign yi        = 32'(req.y_pos >>> FW);
   assign s1_hx_in  = xi * PRIME_X;
   assign s1_hy_in  = yi * PRIME_Y;
   assign s1_tx_in  = req.x_pos[FW-1:0];
   assign s1_ty_in  = req.y_pos[FW-1:0];
   assign s1_tx2_in = s1_tx_in * s1_tx_in;
   assign s1_ty2_in = s1_ty_in * s1_ty_in;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_hx_ff  <= s1_hx_in;
         s1_hy_ff  <= s1_hy_in;
         s1_tx_ff  <= s1_tx_in;
         s1_ty_ff  <= s1_ty_in;
         s1_tx2_ff <= s1_tx2_in;
         s1_ty2_ff <= s1_ty2_in;
      end
   end

   // ---------------- stage 2: corner words, first xor-shift, ease product ----------------
   // corner order: 0 = (x,y), 1 = (x+1,y), 2 = (x,y+1), 3 = (x+1,y+1)
   logic [31:0]       hx1, hy1;
   logic [31:0]       w [4];
   logic [31:0]       s2_v_ff [4];
   logic [31:0]       s2_v_in [4];
   logic [FW+1:0]     fac_x, fac_y;
   logic [2*FW+1:0]   s2_ex_ff, s2_ex_in, s2_ey_ff, s2_ey_in;

   assign hx1  = s1_hx_ff + PRIME_X;
   assign hy1  = s1_hy_ff + PRIME_Y;
   assign w[0] = s1_hx_ff ^ s1_hy_ff ^ seed_mix_ff;
   assign w[1] = hx1 ^ s1_hy_ff ^ seed_mix_ff;
   assign w[2] = s1_hx_ff ^ hy1 ^ seed_mix_ff;
   assign w[3] = hx1 ^ hy1 ^ seed_mix_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s2_v_in[i] = w[i] ^ (w[i] >> 16);
      end
   end

   assign fac_x    = (FW+2)'(3) << FW;
   assign fac_y    = fac_x - {1'b0, s1_ty_ff, 1'b0};
   assign s2_ex_in = s1_tx2_ff[2*FW-1:FW] * (fac_x - {1'b0, s1_tx_ff, 1'b0});
   assign s2_ey_in = s1_ty2_ff[2*FW-1:FW] * fac_y;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_v_ff  <= s2_v_in;
         s2_ex_ff <= s2_ex_in;
         s2_ey_ff <= s2_ey_in;
      end
   end

   // ---------------- stage 3: mixer multiply A ----------------
   logic [31:0]   s3_v_ff [4];
   logic [31:0]   s3_v_in [4];
   logic [FW-1:0] s3_sx_ff, s3_sx_in, s3_sy_ff, s3_sy_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s3_v_in[i] = s2_v_ff[i] * MIX_MUL_A;
      end
   end

   assign s3_sx_in = s2_ex_ff[2*FW-1:FW];
   assign s3_sy_in = s2_ey_ff[2*FW-1:FW];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_v_ff  <= s3_v_in;
         s3_sx_ff <= s3_sx_in;
         s3_sy_ff <= s3_sy_in;
      end
   end

   // ---------------- stage 4: xor-shift, mixer multiply B ----------------
   logic [31:0]   s4_v_ff [4];
   logic [31:0]   s4_v_in [4];
   logic [FW-1:0] s4_sx_ff, s4_sy_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s4_v_in[i] = (s3_v_ff[i] ^ (s3_v_ff[i] >> 15)) * MIX_MUL_B;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_v_ff  <= s4_v_in;
         s4_sx_ff <= s3_sx_ff;
         s4_sy_ff <= s3_sy_ff;
      end
   end

   // ---------------- stage 5: corner values, x differences ----------------
   value_type        c [4];
   value_type        s5_a0_ff, s5_a0_in, s5_a1_ff, s5_a1_in;
   logic [DW-1:0]    s5_d0_ff, s5_d0_in, s5_d1_ff, s5_d1_in;
   logic [FW-1:0]    s5_sx_ff, s5_sy_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         c[i] = VALUE_W'(s4_v_ff[i] ^ (s4_v_ff[i] >> 16));
      end
   end

   assign s5_a0_in = c[0];
   assign s5_a1_in = c[2];
   assign s5_d0_in = {1'b0, c[1]} - {1'b0, c[0]};
   assign s5_d1_in = {1'b0, c[3]} - {1'b0, c[2]};

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_a0_ff <= s5_a0_in;
         s5_a1_ff <= s5_a1_in;
         s5_d0_ff <= s5_d0_in;
         s5_d1_ff <= s5_d1_in;
         s5_sx_ff <= s4_sx_ff;
         s5_sy_ff <= s4_sy_ff;
      end
   end

   // ---------------- stage 6: x lerp products ----------------
   logic signed [FW:0]   sx_s;
   logic signed [PW-1:0] s6_p0_ff, s6_p0_in, s6_p1_ff, s6_p1_in;
   value_type            s6_a0_ff, s6_a1_ff;
   logic [FW-1:0]        s6_sy_ff;

   assign sx_s     = $signed({1'b0, s5_sx_ff});
   assign s6_p0_in = $signed(s5_d0_ff) * sx_s;
   assign s6_p1_in = $signed(s5_d1_ff) * sx_s;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_p0_ff <= s6_p0_in;
         s6_p1_ff <= s6_p1_in;
         s6_a0_ff <= s5_a0_ff;
         s6_a1_ff <= s5_a1_ff;
         s6_sy_ff <= s5_sy_ff;
      end
   end

   // ---------------- stage 7: x lerp sums, y difference ----------------
   logic signed [PW-1:0] q0, q1;
   logic [VALUE_W+1:0]   r0_sum, r1_sum;
   value_type            s7_r0_ff, s7_r0_in;
   logic [DW-1:0]        s7_dy_ff, s7_dy_in;
   logic [FW-1:0]        s7_sy_ff;

   assign q0       = s6_p0_ff >>> FW;
   assign q1       = s6_p1_ff >>> FW;
   assign r0_sum   = {2'b00, s6_a0_ff} + q0[VALUE_W+1:0];
   assign r1_sum   = {2'b00, s6_a1_ff} + q1[VALUE_W+1:0];
   assign s7_r0_in = r0_sum[VALUE_W-1:0];
   assign s7_dy_in = {1'b0, r1_sum[VALUE_W-1:0]} - {1'b0, r0_sum[VALUE_W-1:0]};

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_r0_ff <= s7_r0_in;
         s7_dy_ff <= s7_dy_in;
         s7_sy_ff <= s6_sy_ff;
      end
   end

   // ---------------- stage 8: y lerp product ----------------
   logic signed [PW-1:0] s8_p_ff, s8_p_in;
   value_type            s8_r0_ff;

   assign s8_p_in = $signed(s7_dy_ff) * $signed({1'b0, s7_sy_ff});

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s8_p_ff  <= s8_p_in;
         s8_r0_ff <= s7_r0_ff;
      end
   end

   // ---------------- stage 9: y lerp sum, response register ----------------
   logic signed [PW-1:0] qy;
   logic [VALUE_W+1:0]   out_sum;
   value_type            s9_out_ff, s9_out_in;

   assign qy        = s8_p_ff >>> FW;
   assign out_sum   = {2'b00, s8_r0_ff} + qy[VALUE_W+1:0];
   assign s9_out_in = out_sum[VALUE_W-1:0];

   always_ff @(posedge clock) begin
      if (en[8]) begin
         s9_out_ff <= s9_out_in;
      end
   end

   assign rsp.valid       = v_ff[NSTG-1];
   assign rsp.noise_value = s9_out_ff;

   // ---------------- assertions ----------------
   a_ready_only_blocked: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp.valid && !rsp.ready))
      else $error("request stalled while response side free");

   a_enter_stage: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> v_ff[0])
      else $error("accepted request lost at first stage");

   a_seed_mix: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_sel) |=> (seed_mix_ff == 32'($past(csr_pwdata) * PRIME_SEED)))
      else $error("seed product out of step with seed write");

endmodule

// ----- dv/hashed_value_noise_2d_top_test.sv -----
`timescale 1ns / 1ps
// Testbench for the hashed 2D value noise block: streams points, predicts and checks noise, checks seed readback.
module hashed_value_noise_2d_top_test;
   import hvn2d_pkg::*;

   localparam int FRAC          = FRAC_BITS_DEF;
   localparam int RANDOM_POINTS = 600;
   localparam int RANDOM_PHASES = 7;
   localparam int LONG_STALL    = 60;
   localparam int DRAIN_CYCLES  = 20;
   localparam int QUIET_LIMIT   = 4000;
   localparam reg_index_type UNMAPPED_INDEX = reg_index_type'(1);

   typedef struct packed {
      bit [COORD_W-1:0] x_pos;
      bit [COORD_W-1:0] y_pos;
   } point_type;

   typedef struct packed {
      point_type pt;
      value_type noise;
   } noise_due_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   hvn2d_req_if req_ch();
   hvn2d_rsp_if rsp_ch();

   hashed_value_noise_2d_top uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   point_type     points[$];
   noise_due_type noise_due[$];
   bit [31:0]  seed_model;
   bit         req_calm;
   bit         rsp_calm;
   bit         req_fire;
   int         req_idle;
   int         rsp_hold;
   int         stall_asks;
   int         stall_served;
   int         requests_taken;
   int         values_checked;
   int         value_errors;
   int         csr_errors;
   int         seeds_used;
   int         directed_count;
   int         stall_run;
   int         longest_stall;
   int         quiet_cycles;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------------------------------------------------------- predictor
   function automatic bit [31:0] scramble(bit [31:0] v);
      v ^= v >> 16;
      v = v * MIX_MUL_A;
      v ^= v >> 15;
      v = v * MIX_MUL_B;
      v ^= v >> 16;
      return v;
   endfunction

   function automatic value_type lattice_hash(bit [31:0] cx, bit [31:0] cy, bit [31:0] seed);
      bit [31:0] w;
      bit [31:0] m;
      w = (cx * PRIME_X) ^ (cy * PRIME_Y) ^ (seed * PRIME_SEED);
      m = scramble(w);
      return m[VALUE_W-1:0];
   endfunction

   function automatic bit [63:0] smooth_weight(bit [63:0] t);
      bit [63:0] t2;
      t2 = (t * t) >> FRAC;
      return (t2 * ((64'd3 << FRAC) - 2 * t)) >> FRAC;
   endfunction

   function automatic value_type lerp_floor(value_type a, value_type b, bit [63:0] s);
      longint d;
      longint p;
      longint q;
      d = longint'(b) - longint'(a);
      p = d * longint'(s);
      q = p >>> FRAC;
      return value_type'(longint'(a) + q);
   endfunction

   function automatic value_type expected_noise(bit [31:0] px, bit [31:0] py, bit [31:0] seed);
      bit [31:0] xi;
      bit [31:0] yi;
      bit [63:0] wx;
      bit [63:0] wy;
      value_type r0;
      value_type r1;
      xi = $signed(px) >>> FRAC;
      yi = $signed(py) >>> FRAC;
      wx = smooth_weight(64'(px[FRAC-1:0]));
      wy = smooth_weight(64'(py[FRAC-1:0]));
      r0 = lerp_floor(lattice_hash(xi, yi, seed), lattice_hash(xi + 32'd1, yi, seed), wx);
      r1 = lerp_floor(lattice_hash(xi, yi + 32'd1, seed),
                      lattice_hash(xi + 32'd1, yi + 32'd1, seed), wx);
      return lerp_floor(r0, r1, wy);
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic int pick_gap(bit calm);
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(8, 40);
      end
   endfunction

   function automatic bit [31:0] pick_coord();
      bit [31:0] c;
      c = $urandom;
      case ($urandom_range(0, 3))
         0: begin
         end
         1: begin
            c = (c & ((32'd1 << FRAC) - 1)) | (32'($signed(3'($urandom))) << FRAC);
         end
         2: begin
            case ($urandom_range(0, 3))
               0: c[FRAC-1:0] = '0;
               1: c[FRAC-1:0] = FRAC'(1);
               2: c[FRAC-1:0] = '1;
               default: c[FRAC-1:0] = FRAC'(1) << (FRAC - 1);
            endcase
         end
         default: begin
            if ($urandom_range(0, 1)) begin
               c = 32'h7fff_ffff - $urandom_range(0, 3 << FRAC);
            end else begin
               c = 32'h8000_0000 + $urandom_range(0, 3 << FRAC);
            end
         end
      endcase
      return c;
   endfunction

   task automatic add_point(bit [31:0] x, bit [31:0] y);
      point_type p;
      p.x_pos = x;
      p.y_pos = y;
      points.push_back(p);
   endtask

   task automatic wait_drained();
      while (points.size() != 0 || req_ch.valid || noise_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(reg_index_type idx, bit [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_NOISE_SEED) begin
         seed_model = val;
      end
   endtask

   task automatic csr_read_check();
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {REG_NOISE_SEED, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== seed_model) begin
         $display("%0t: noise_seed readback expected %h actual %h", $time, seed_model, got);
         csr_errors++;
      end
   endtask

   // ---------------------------------------------------------------- request driver
   always @(negedge clock) begin
      point_type p;
      if (!reset && (!req_ch.valid || req_fire)) begin
         if (req_idle > 0) begin
            req_ch.valid <= 1'b0;
            req_idle     <= req_idle - 1;
         end else if (points.size() != 0) begin
            p = points.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.x_pos <= p.x_pos;
            req_ch.y_pos <= p.y_pos;
            req_idle     <= pick_gap(req_calm);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- response receiver
   always @(negedge clock) begin
      int n;
      if (!reset) begin
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold     <= rsp_hold - 1;
         end else if (stall_asks != stall_served) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold     <= LONG_STALL - 1;
            stall_served <= stall_asks;
         end else begin
            n = pick_gap(rsp_calm);
            if (n > 0) begin
               rsp_ch.ready <= 1'b0;
               rsp_hold     <= n - 1;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor and checker
   always @(posedge clock) begin
      noise_due_type e;
      if (reset) begin
         req_fire  <= 1'b0;
         stall_run = 0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (noise_due.size() == 0) begin
               $display("%0t: unexpected noise_value expected none actual %h",
                        $time, rsp_ch.noise_value);
               value_errors++;
            end else begin
               e = noise_due.pop_front();
               values_checked++;
               if (rsp_ch.noise_value !== e.noise) begin
                  $display("%0t: noise_value expected %h actual %h (x %h y %h)",
                           $time, e.noise, rsp_ch.noise_value, e.pt.x_pos, e.pt.y_pos);
                  value_errors++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            e.pt.x_pos = req_ch.x_pos;
            e.pt.y_pos = req_ch.y_pos;
            e.noise    = expected_noise(req_ch.x_pos, req_ch.y_pos, seed_model);
            noise_due.push_back(e);
            requests_taken++;
         end
         if (req_ch.valid && !req_ch.ready) begin
            stall_run++;
            if (stall_run > longest_stall) begin
               longest_stall = stall_run;
            end
         end else begin
            stall_run = 0;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || csr_psel || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      bit [31:0] seed;
      int        n;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.x_pos = '0;
      req_ch.y_pos = '0;
      rsp_ch.ready = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      seed_model   = '0;
      req_calm     = 1'b0;
      rsp_calm     = 1'b0;
      req_idle     = 0;
      rsp_hold     = 0;
      stall_asks   = 0;
      stall_served = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read_check();
      add_point(32'h0000_0000, 32'h0000_0000);
      add_point(32'h7fff_ffff, 32'h7fff_ffff);
      add_point(32'h8000_0000, 32'h8000_0000);
      add_point(32'hffff_ffff, 32'hffff_ffff);
      add_point(32'h7fff_ffff, 32'h8000_0000);
      add_point(32'h8000_0000, 32'h7fff_ffff);
      add_point(32'h0000_ffff, 32'h0000_0000);
      add_point(32'h0000_0000, 32'h0000_ffff);
      add_point(32'h0000_8000, 32'h0000_8000);
      add_point(32'h0000_0001, 32'h0000_0001);
      add_point(32'hffff_8000, 32'hffff_0001);
      add_point(32'hffff_0000, 32'h0001_0000);
      add_point(32'h7fff_0000, 32'h8000_ffff);
      add_point(32'h0003_c000, 32'hfffd_4000);
      add_point(32'h1234_5678, 32'hedcb_a987);
      add_point(32'hffff_fffe, 32'h0000_fffe);
      directed_count = points.size();
      seeds_used = 1;
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: seed = 32'hffff_ffff;
            2: seed = 32'h0000_0000;
            3: seed = 32'h0000_0001;
            4: seed = 32'h8000_0000;
            default: seed = $urandom;
         endcase
         csr_write(REG_NOISE_SEED, seed);
         csr_read_check();
         if (ph == 5) begin
            csr_write(UNMAPPED_INDEX, ~seed);
            csr_read_check();
         end
         seeds_used++;
         req_calm = (ph == 4) || (ph == 6);
         rsp_calm = (ph == 2) || (ph == 6);
         n = (RANDOM_POINTS + RANDOM_PHASES - 1) / RANDOM_PHASES;
         repeat (n) add_point(pick_coord(), pick_coord());
         if (ph == 4) begin
            stall_asks++;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (noise_due.size() != 0) begin
         $display("%0t: outstanding noise values expected 0 actual %0d",
                  $time, noise_due.size());
         value_errors++;
      end
      $display("%0d requests, %0d noise values checked over %0d seed settings (%0d directed)",
               requests_taken, values_checked, seeds_used, directed_count);
      $display("longest input stall behind held-off responses: %0d cycles", longest_stall);
      if (value_errors == 0 && csr_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/hvn2d_pkg.sv
rtl/hvn2d_chan_if.sv
rtl/hashed_value_noise_2d_top.sv
dv/hashed_value_noise_2d_top_test.sv
